// File: sv/sdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared widths, register codes, reset values and record types for the
// step/direction pulse generator.
// ----------------------------------------------------------------------------
package sdp_pkg;

	localparam int POS_W      = 15;
	localparam int TICK_W     = 16;
	localparam int STEPS_W    = 16;
	localparam int MSSEL_W    = 8;
	localparam int MS_W       = 3;
	localparam int MSIDX_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POSITION     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_TICKS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MICROSTEP_SELECT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MICROSTEP_ENABLE = 3'd3;

	// Command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_MOVE = 1'b1;

	// Register reset values (soft limit is 200 steps/rev times 80 revs)
	localparam logic [POS_W-1:0]   MAX_POSITION_RST = POS_W'(200 * 80);
	localparam logic [TICK_W-1:0]  HIGH_TICKS_RST   = TICK_W'(20);
	localparam logic [MSSEL_W-1:0] MSSEL_RST        = 8'd1;
	localparam logic               MSEN_RST         = 1'b1;

	// Saturated step count for the most negative request
	localparam logic [POS_W-1:0] STEPS_SAT = {POS_W{1'b1}};

	// Microstep pin codes (ms3 ms2 ms1)
	localparam logic [MS_W-1:0] MS_FULL    = 3'b000;
	localparam logic [MS_W-1:0] MS_HALF    = 3'b001;
	localparam logic [MS_W-1:0] MS_QUARTER = 3'b010;
	localparam logic [MS_W-1:0] MS_EIGHTH  = 3'b011;
	localparam logic [MS_W-1:0] MS_SIXTEEN = 3'b111;

	typedef struct packed {
		logic [POS_W-1:0]   max_position;
		logic [TICK_W-1:0]  high_ticks;
		logic [MSSEL_W-1:0] microstep_select;
		logic               microstep_enable;
	} cfg_t;

	typedef struct packed {
		logic               step_level;
		logic               direction;
		logic               sleep_level;
		logic [MS_W-1:0]    ms_pins;
		logic               timer_on;
		logic [POS_W-1:0]   position_count;
		logic [POS_W-1:0]   remaining;
		logic [TICK_W-1:0]  tick_count;
		logic [TICK_W-1:0]  low_period;
	} state_t;

	// Map the chosen microstep bit position to the pin code
	function automatic logic [MS_W-1:0] ms_code_of(input logic [MSIDX_W-1:0] sel);
		logic [MS_W-1:0] code;
		case (sel)
			3'd0:    code = MS_FULL;
			3'd1:    code = MS_HALF;
			3'd2:    code = MS_QUARTER;
			3'd3:    code = MS_EIGHTH;
			default: code = MS_SIXTEEN;
		endcase
		return code;
	endfunction

endpackage

// File: sv/sdp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_if
// Valid/ready channels of the pulse generator: command items, result items
// and configuration writes.
// ----------------------------------------------------------------------------
interface sdp_item_if import sdp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic signed [STEPS_W-1:0] move_steps;
	logic [TICK_W-1:0]         low_ticks;

	modport source (output valid, command, move_steps, low_ticks, input ready);
	modport sink   (input valid, command, move_steps, low_ticks, output ready);
endinterface

interface sdp_result_if import sdp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             step_out;
	logic             dir_out;
	logic             sleep_out;
	logic [MS_W-1:0]  ms_code;
	logic             running;
	logic [POS_W-1:0] position;
	logic [POS_W-1:0] steps_left;
	logic             move_rejected;

	modport source (output valid, step_out, dir_out, sleep_out, ms_code, running,
		position, steps_left, move_rejected, input ready);
	modport sink   (input valid, step_out, dir_out, sleep_out, ms_code, running,
		position, steps_left, move_rejected, output ready);
endinterface

interface sdp_cfg_if import sdp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/sdp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_cfg
// Configuration register file: soft limit, high phase reload and microstep
// setting, written one register per transfer.
// ----------------------------------------------------------------------------
module sdp_cfg import sdp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	sdp_cfg_if.sink  cfg,
	output cfg_t     regs
);

	cfg_t regs_q;

	// Always able to take a write
	assign cfg.ready = 1'b1;

	// Decode the index and update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.max_position     <= MAX_POSITION_RST;
			regs_q.high_ticks       <= HIGH_TICKS_RST;
			regs_q.microstep_select <= MSSEL_RST;
			regs_q.microstep_enable <= MSEN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAX_POSITION:     regs_q.max_position     <= cfg.data[POS_W-1:0];
				REG_HIGH_TICKS:       regs_q.high_ticks       <= cfg.data[TICK_W-1:0];
				REG_MICROSTEP_SELECT: regs_q.microstep_select <= cfg.data[MSSEL_W-1:0];
				REG_MICROSTEP_ENABLE: regs_q.microstep_enable <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// File: sv/sdp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_core
// Motion state and its update per item: move start or refusal, tick
// countdown, phase toggle, step and position counting, soft limit stop.
// ----------------------------------------------------------------------------
module sdp_core import sdp_pkg::*; #(
	parameter int MICROSTEP_CHOICES = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic                      command,
	input  logic signed [STEPS_W-1:0] move_steps,
	input  logic [TICK_W-1:0]         low_ticks,
	input  cfg_t                      regs,
	output state_t                    nxt,
	output logic                      rejected
);

	state_t               state_q;
	logic                 found;
	logic [MSIDX_W-1:0]   sel;
	logic                 move_ok;
	logic [STEPS_W-1:0]   raw;
	logic [STEPS_W-1:0]   neg_mag;
	logic [POS_W-1:0]     mag;
	logic                 at_limit;

	// Pick the lowest set bit among the allowed microstep choices
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int i = MICROSTEP_CHOICES - 1; i >= 0; i--) begin
			if (regs.microstep_select[i]) begin
				found = 1'b1;
				sel   = MSIDX_W'(i);
			end
		end
	end

	assign move_ok = !regs.microstep_enable || found;

	// Magnitude of the signed step count, saturating the most negative value
	assign raw     = move_steps;
	assign neg_mag = (~raw) + STEPS_W'(1);
	assign mag     = raw[STEPS_W-1] ? (neg_mag[STEPS_W-1] ? STEPS_SAT : neg_mag[POS_W-1:0])
	                                : raw[POS_W-1:0];

	// Soft limit seen before a rising edge
	assign at_limit = state_q.direction ? (state_q.position_count == '0)
	                                    : (state_q.position_count >= regs.max_position);

	// Next state for the item in hand
	always_comb begin
		nxt      = state_q;
		rejected = 1'b0;
		if (command == CMD_MOVE) begin
			if (!move_ok) begin
				rejected = 1'b1;
			end else begin
				if (regs.microstep_enable) begin
					nxt.ms_pins = ms_code_of(sel);
				end
				nxt.direction   = raw[STEPS_W-1];
				nxt.remaining   = mag;
				nxt.low_period  = low_ticks;
				nxt.tick_count  = low_ticks;
				nxt.step_level  = 1'b0;
				nxt.sleep_level = 1'b1;
				nxt.timer_on    = 1'b1;
			end
		end else if (state_q.timer_on) begin
			if (state_q.tick_count != '0) begin
				nxt.tick_count = state_q.tick_count - TICK_W'(1);
			end else if (state_q.remaining == '0) begin
				nxt.step_level = 1'b0;
				nxt.timer_on   = 1'b0;
			end else if (state_q.step_level) begin
				nxt.step_level = 1'b0;
				nxt.tick_count = state_q.low_period;
			end else if (at_limit) begin
				nxt.step_level = 1'b0;
				nxt.timer_on   = 1'b0;
				nxt.remaining  = '0;
			end else begin
				nxt.step_level = 1'b1;
				nxt.tick_count = regs.high_ticks;
				nxt.remaining  = state_q.remaining - POS_W'(1);
				nxt.position_count = state_q.direction ?
					state_q.position_count - POS_W'(1) :
					state_q.position_count + POS_W'(1);
			end
		end
	end

	// Commit the update when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= nxt;
		end
	end

endmodule

// File: sv/step_dir_pulse_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_dir_pulse_generator
// Step/direction pulse generator with soft position limits.
//
// Items arrive on the items channel: a tick (command 0) counts the pulse
// timer down, a move (command 1) loads a signed step count and the low phase
// period and starts the timer. Every item gives exactly one result on the
// results channel with the pin levels, position and steps left after it.
// Registers are written on the cfg channel, which is always ready.
//
// The item sits in the input register until the result register can take
// it; its result is then loaded into the result register and offered on
// the results channel. Items are taken at one per cycle while results are
// taken; the state update between the two registers is combinational.
// When results stall, the result register holds, the input register holds
// one more item, and items.ready drops until the result is taken.
// Reset clears the motion state and the channel valids and loads the
// register defaults (limit 16000, high phase 20, microstep bit 0, enabled).
// ----------------------------------------------------------------------------
module step_dir_pulse_generator import sdp_pkg::*; #(
	parameter int MICROSTEP_CHOICES = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	sdp_item_if.sink      items,
	sdp_result_if.source  results,
	sdp_cfg_if.sink       cfg
);

	cfg_t                      regs;
	state_t                    nxt;
	logic                      rejected;

	logic                      valid_s1;
	logic                      command_s1;
	logic signed [STEPS_W-1:0] move_steps_s1;
	logic [TICK_W-1:0]         low_ticks_s1;
	logic                      out_free;
	logic                      adv_s1;

	logic                      res_valid_q;
	state_t                    res_state_q;
	logic                      res_rejected_q;

	sdp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sdp_core #(
		.MICROSTEP_CHOICES (MICROSTEP_CHOICES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (adv_s1),
		.command    (command_s1),
		.move_steps (move_steps_s1),
		.low_ticks  (low_ticks_s1),
		.regs       (regs),
		.nxt        (nxt),
		.rejected   (rejected)
	);

	// Stage handshake
	assign out_free    = !res_valid_q || results.ready;
	assign adv_s1      = valid_s1 && out_free;
	assign items.ready = !valid_s1 || out_free;

	// Input register: hold the item until its result can be written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			command_s1    <= items.command;
			move_steps_s1 <= items.move_steps;
			low_ticks_s1  <= items.low_ticks;
		end
	end

	// Result register: drop valid once taken, load on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_state_q    <= nxt;
			res_rejected_q <= rejected;
		end
	end

	assign results.valid         = res_valid_q;
	assign results.step_out      = res_state_q.step_level;
	assign results.dir_out       = res_state_q.direction;
	assign results.sleep_out     = res_state_q.sleep_level;
	assign results.ms_code       = res_state_q.ms_pins;
	assign results.running       = res_state_q.timer_on;
	assign results.position      = res_state_q.position_count;
	assign results.steps_left    = res_state_q.remaining;
	assign results.move_rejected = res_rejected_q;

	// A high step pin only while the timer runs
	a_step_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.step_out |-> results.running)
		else $error("step pin high with timer stopped");

	// A running timer implies the driver is awake
	a_run_needs_wake: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.running |-> results.sleep_out)
		else $error("timer running while sleep pin low");

	// A held item in the input register is not lost
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("input stage dropped an item under stall");

	// A refused move leaves the motion state untouched
	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && rejected |-> nxt == u_core.state_q)
		else $error("refused move changed state");

endmodule
